>>> rtl/bcmfb_pkg.sv
package bcmfb_pkg;

    // Default geometry of the matrix.
    localparam int ROWS_DEF   = 8;
    localparam int PANELS_DEF = 1;
    localparam int PLANES_DEF = 8;

    localparam int CH_COUNT = 3;

    typedef enum logic [2:0] {
        OP_PIXEL = 3'd0,
        OP_ROW   = 3'd1,
        OP_COL   = 3'd2,
        OP_FILL  = 3'd3,
        OP_QUERY = 3'd4,
        OP_SCAN  = 3'd5
    } t_op;

    // Command after range clamping, as it travels from front to back.
    typedef struct packed {
        t_op        op;
        logic [2:0] row;
        logic [4:0] column;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] plane;
    } t_cmd;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       led_on;
        logic       last;
    } t_res;

endpackage

>>> rtl/bcmfb_fifo.sv
module bcmfb_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    // Two-entry queue.
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_wr;
    logic         w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/bcmfb_front.sv
module bcmfb_front #(
    parameter int ROWS   = bcmfb_pkg::ROWS_DEF,
    parameter int PANELS = bcmfb_pkg::PANELS_DEF,
    parameter int PLANES = bcmfb_pkg::PLANES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [2:0]       i_opcode,
    input  logic [2:0]       i_row,
    input  logic [4:0]       i_column,
    input  logic [7:0]       i_red,
    input  logic [7:0]       i_green,
    input  logic [7:0]       i_blue,
    input  logic [2:0]       i_plane,
    input  logic             i_cmd_pop,
    output bcmfb_pkg::t_cmd  o_cmd,
    output logic             o_cmd_empty
);

    localparam logic [2:0] RowMax   = 3'(ROWS - 1);
    localparam logic [4:0] ColMax   = 5'(8 * PANELS - 1);
    localparam logic [2:0] PlaneMax = 3'(PLANES - 1);

    bcmfb_pkg::t_cmd w_cmd;
    logic            w_known;

    // Unused opcodes are taken and dropped here.
    always_comb begin
        w_known = i_opcode inside {[3'd0:3'd5]};
        w_cmd.op     = bcmfb_pkg::t_op'(i_opcode);
        w_cmd.row    = (i_row > RowMax) ? RowMax : i_row;
        w_cmd.column = (i_column > ColMax) ? ColMax : i_column;
        w_cmd.red    = i_red;
        w_cmd.green  = i_green;
        w_cmd.blue   = i_blue;
        w_cmd.plane  = (i_plane > PlaneMax) ? PlaneMax : i_plane;
    end

    bcmfb_fifo #(
        .W ($bits(bcmfb_pkg::t_cmd))
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_known),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

>>> rtl/bcmfb_back.sv
module bcmfb_back #(
    parameter int ROWS   = bcmfb_pkg::ROWS_DEF,
    parameter int PANELS = bcmfb_pkg::PANELS_DEF,
    parameter int PLANES = bcmfb_pkg::PLANES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bcmfb_pkg::t_cmd  i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    output logic             o_res_push,
    output bcmfb_pkg::t_res  o_res,
    input  logic             i_res_full
);

    localparam int ENTRIES = ROWS * PANELS;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW      = (PANELS > 1) ? $clog2(PANELS) : 1;
    localparam int WW      = bcmfb_pkg::CH_COUNT * PLANES * 8;
    localparam int IW      = $clog2(WW);
    localparam logic [2:0]    RowLast   = 3'(ROWS - 1);
    localparam logic [PW-1:0] PanelLast = PW'(PANELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ROWSEL
    } t_state;

    // One word holds every channel and plane byte of one row of one panel.
    logic [WW-1:0]   r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_vld;
    logic [WW-1:0]   r_rdata;
    logic            r_rd_ok;

    t_state          r_state;
    bcmfb_pkg::t_cmd r_cmd;
    logic [2:0]      r_cr;
    logic [PW-1:0]   r_cb;
    logic [1:0]      r_ch;

    logic [AW-1:0]   w_addr;
    logic [WW-1:0]   w_word;
    logic [WW-1:0]   w_wdata;
    logic            w_we;
    logic [7:0]      w_mask;
    logic [7:0]      w_col [3];
    logic            w_lit;
    logic [IW-1:0]   w_sidx;
    logic            w_is_wr;
    logic            w_last_ent;

    assign w_addr = AW'(32'(r_cr) * PANELS + 32'(r_cb));
    assign w_word = r_rd_ok ? r_rdata : '0;
    assign w_is_wr = (r_cmd.op == bcmfb_pkg::OP_PIXEL) || (r_cmd.op == bcmfb_pkg::OP_ROW)
                  || (r_cmd.op == bcmfb_pkg::OP_COL) || (r_cmd.op == bcmfb_pkg::OP_FILL);
    assign w_we   = (r_state == S_EXEC) && w_is_wr;
    assign w_sidx = IW'((32'(r_ch) * PLANES + 32'(r_cmd.plane)) * 8);

    always_comb begin
        logic [7:0] v_byte;
        w_col[0] = r_cmd.red;
        w_col[1] = r_cmd.green;
        w_col[2] = r_cmd.blue;
        if ((r_cmd.op == bcmfb_pkg::OP_PIXEL) || (r_cmd.op == bcmfb_pkg::OP_COL)) begin
            w_mask = 8'd1 << r_cmd.column[2:0];
        end else begin
            w_mask = 8'hFF;
        end
        w_wdata = w_word;
        w_lit   = 1'b0;
        for (int ch = 0; ch < bcmfb_pkg::CH_COUNT; ch++) begin
            for (int p = 0; p < PLANES; p++) begin
                v_byte = w_word[(ch * PLANES + p) * 8 +: 8];
                w_lit  = w_lit | v_byte[r_cmd.column[2:0]];
                w_wdata[(ch * PLANES + p) * 8 +: 8] =
                    w_col[ch][p] ? (v_byte | w_mask) : (v_byte & ~w_mask);
            end
        end
    end

    always_comb begin
        case (r_cmd.op)
            bcmfb_pkg::OP_ROW:  w_last_ent = (r_cb == PanelLast);
            bcmfb_pkg::OP_COL:  w_last_ent = (r_cr == RowLast);
            bcmfb_pkg::OP_FILL: w_last_ent = (r_cb == PanelLast) && (r_cr == RowLast);
            default:            w_last_ent = 1'b1;
        endcase
    end

    always_comb begin
        o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
        o_res_push = 1'b0;
        o_res      = '0;
        case (r_state)
            S_EXEC: begin
                if (r_cmd.op == bcmfb_pkg::OP_QUERY) begin
                    o_res_push = !i_res_full;
                    o_res.led_on = w_lit;
                    o_res.last   = 1'b1;
                end else if (r_cmd.op == bcmfb_pkg::OP_SCAN) begin
                    o_res_push = !i_res_full;
                    o_res.data_byte = w_word[w_sidx +: 8];
                end
            end
            S_ROWSEL: begin
                o_res_push = !i_res_full;
                o_res.data_byte = 8'd1 << r_cmd.row;
                o_res.last      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cr    <= '0;
            r_cb    <= '0;
            r_ch    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd <= i_cmd;
                        r_ch  <= '0;
                        r_cr  <= ((i_cmd.op == bcmfb_pkg::OP_COL)
                                  || (i_cmd.op == bcmfb_pkg::OP_FILL)) ? 3'd0 : i_cmd.row;
                        if ((i_cmd.op == bcmfb_pkg::OP_ROW) || (i_cmd.op == bcmfb_pkg::OP_FILL)) begin
                            r_cb <= '0;
                        end else if (i_cmd.op == bcmfb_pkg::OP_SCAN) begin
                            r_cb <= PanelLast;
                        end else begin
                            r_cb <= PW'(i_cmd.column >> 3);
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_is_wr) begin
                        if (w_last_ent) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_READ;
                            case (r_cmd.op)
                                bcmfb_pkg::OP_ROW: r_cb <= r_cb + 1'b1;
                                bcmfb_pkg::OP_COL: r_cr <= r_cr + 3'd1;
                                default: begin
                                    if (r_cb == PanelLast) begin
                                        r_cb <= '0;
                                        r_cr <= r_cr + 3'd1;
                                    end else begin
                                        r_cb <= r_cb + 1'b1;
                                    end
                                end
                            endcase
                        end
                    end else if (!i_res_full) begin
                        if (r_cmd.op == bcmfb_pkg::OP_QUERY) begin
                            r_state <= S_IDLE;
                        end else if (r_ch == 2'd2) begin
                            r_ch <= '0;
                            if (r_cb == '0) begin
                                r_state <= S_ROWSEL;
                            end else begin
                                r_cb    <= r_cb - 1'b1;
                                r_state <= S_READ;
                            end
                        end else begin
                            r_ch <= r_ch + 2'd1;
                        end
                    end
                end
                S_ROWSEL: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Entries never written since reset read back as dark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
        r_rd_ok <= r_vld[w_addr];
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == S_READ))
        else $error("command taken without starting a read");
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch != 2'd3)
        else $error("channel counter out of range");
    a_we_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ($past(r_state) == S_READ))
        else $error("store written without a fresh read");
`endif

endmodule

>>> rtl/bcm_rgb_matrix_framebuffer.sv
// Bit-plane frame store for an RGB LED matrix with binary code modulation.
// Input channel: a command beat is taken when push is high and full is low.
// Opcodes set a pixel, a row, a column or the whole matrix, query one pixel
// or scan one row of one bit plane. Row, column and plane are clamped to the
// matrix size, and unknown opcodes are taken and dropped.
// Result channel: while empty is low the oldest result beat is on the ports;
// pop takes it. A query gives one beat, a scan gives three beats per panel
// (last panel first, red, green, blue) and a one-hot row-select beat flagged
// by last. Writes give no beat.
// Flow: a beat enters a two-entry command queue. The back end fetches it,
// then per stored row word does one registered read of the single-port
// store and one modify step for a write or one emit step per result beat:
// a pixel write or query touches one word, a column ROWS words, a fill
// ROWS*PANELS words, and a scan one word per panel (one read and three emit
// steps each), then emits the row-select beat. A stalled receiver fills the
// two-entry result queue, which then holds the back end; the command queue
// keeps accepting until it too fills.
// Reset clears the per-word valid bits, so the whole display reads dark.
module bcm_rgb_matrix_framebuffer #(
    parameter int ROWS   = bcmfb_pkg::ROWS_DEF,
    parameter int PANELS = bcmfb_pkg::PANELS_DEF,
    parameter int PLANES = bcmfb_pkg::PLANES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_opcode,
    input  logic [2:0] i_row,
    input  logic [4:0] i_column,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [2:0] i_plane,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] o_data_byte,
    output logic       o_led_on,
    output logic       o_last
);

    bcmfb_pkg::t_cmd w_cmd;
    logic            w_cmd_empty;
    logic            w_cmd_pop;
    bcmfb_pkg::t_res w_res;
    logic            w_res_push;
    logic            w_res_full;
    bcmfb_pkg::t_res w_out;

    bcmfb_front #(
        .ROWS   (ROWS),
        .PANELS (PANELS),
        .PLANES (PLANES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_plane     (i_plane),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty)
    );

    bcmfb_back #(
        .ROWS   (ROWS),
        .PANELS (PANELS),
        .PLANES (PLANES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    // Result queue parts the engine from a stalling receiver.
    bcmfb_fifo #(
        .W ($bits(bcmfb_pkg::t_res))
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_out),
        .o_empty (empty)
    );

    assign o_data_byte = w_out.data_byte;
    assign o_led_on    = w_out.led_on;
    assign o_last      = w_out.last;

endmodule

>>> sim/bcm_rgb_matrix_framebuffer_tb.sv
module bcm_rgb_matrix_framebuffer_tb;

    localparam int ROWS      = bcmfb_pkg::ROWS_DEF;
    localparam int PANELS    = bcmfb_pkg::PANELS_DEF;
    localparam int PLANES    = bcmfb_pkg::PLANES_DEF;
    localparam int COLS      = 8 * PANELS;
    localparam int MAX_CYC   = 400000;
    localparam int DRAIN_CYC = 200;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] row;
        logic [4:0] column;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] plane;
    } t_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [2:0] i_opcode;
    logic [2:0] i_row;
    logic [4:0] i_column;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic [2:0] i_plane;
    logic       pop;
    logic       empty;
    logic [7:0] o_data_byte;
    logic       o_led_on;
    logic       o_last;

    bcm_rgb_matrix_framebuffer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_opcode   (i_opcode),
        .i_row      (i_row),
        .i_column   (i_column),
        .i_red      (i_red),
        .i_green    (i_green),
        .i_blue     (i_blue),
        .i_plane    (i_plane),
        .pop        (pop),
        .empty      (empty),
        .o_data_byte(o_data_byte),
        .o_led_on   (o_led_on),
        .o_last     (o_last)
    );

    // Shadow copy of the bit-plane store: channel, plane, row, panel.
    logic [7:0] shadow_planes [3][PLANES][ROWS][PANELS];

    t_beat           pending_cmds[$];
    bcmfb_pkg::t_res expected_beats[$];

    int  errors;
    int  cycle_count;
    int  beats_checked;
    int  queries_sent;
    int  scans_sent;
    bit  stim_done;
    bit  hold_off;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on beat %0d: %s got %0h expected %0h",
                 beats_checked, what, got, want);
        errors++;
    endtask

    // Writes one bit (mask) or a whole byte of every channel and plane.
    task automatic paint(input int r, input int pan, input logic [7:0] mask,
                         input logic [7:0] colors [3]);
        for (int ch = 0; ch < 3; ch++) begin
            for (int p = 0; p < PLANES; p++) begin
                if (colors[ch][p])
                    shadow_planes[ch][p][r][pan] |= mask;
                else
                    shadow_planes[ch][p][r][pan] &= ~mask;
            end
        end
    endtask

    // Updates the shadow store for one accepted command and queues its results.
    task automatic predict_frame(input t_beat cmd);
        int r;
        int c;
        int p;
        int pan;
        logic [7:0] bitmask;
        logic [7:0] colors [3];
        logic lit;
        bcmfb_pkg::t_res res;
        r = (cmd.row > ROWS - 1) ? ROWS - 1 : cmd.row;
        c = (cmd.column > COLS - 1) ? COLS - 1 : cmd.column;
        p = (cmd.plane > PLANES - 1) ? PLANES - 1 : cmd.plane;
        pan = c / 8;
        bitmask = 8'(1 << (c % 8));
        colors[0] = cmd.red;
        colors[1] = cmd.green;
        colors[2] = cmd.blue;
        case (cmd.opcode)
            bcmfb_pkg::OP_PIXEL: paint(r, pan, bitmask, colors);
            bcmfb_pkg::OP_ROW: begin
                for (int j = 0; j < PANELS; j++) paint(r, j, 8'hFF, colors);
            end
            bcmfb_pkg::OP_COL: begin
                for (int k = 0; k < ROWS; k++) paint(k, pan, bitmask, colors);
            end
            bcmfb_pkg::OP_FILL: begin
                for (int k = 0; k < ROWS; k++)
                    for (int j = 0; j < PANELS; j++) paint(k, j, 8'hFF, colors);
            end
            bcmfb_pkg::OP_QUERY: begin
                lit = 1'b0;
                for (int ch = 0; ch < 3; ch++)
                    for (int q = 0; q < PLANES; q++)
                        if (shadow_planes[ch][q][r][pan] & bitmask) lit = 1'b1;
                res.data_byte = 8'h00;
                res.led_on = lit;
                res.last = 1'b1;
                expected_beats.push_back(res);
            end
            bcmfb_pkg::OP_SCAN: begin
                for (int j = PANELS - 1; j >= 0; j--) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        res.data_byte = shadow_planes[ch][p][r][j];
                        res.led_on = 1'b0;
                        res.last = 1'b0;
                        expected_beats.push_back(res);
                    end
                end
                res.data_byte = 8'(1 << r);
                res.led_on = 1'b0;
                res.last = 1'b1;
                expected_beats.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic t_beat make_beat(input logic [2:0] op, input int r, input int c,
                                        input int red, input int green, input int blue,
                                        input int p);
        t_beat b;
        b.opcode = op;
        b.row = 3'(r);
        b.column = 5'(c);
        b.red = 8'(red);
        b.green = 8'(green);
        b.blue = 8'(blue);
        b.plane = 3'(p);
        return b;
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        int pick;
        b = make_beat(bcmfb_pkg::OP_PIXEL, $urandom_range(0, 7), $urandom_range(0, 31),
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 7));
        // Mostly pixel writes, queries and scans so the store is read back
        // often; the wide writes and the unused opcodes show up less.
        pick = $urandom_range(0, 99);
        if (pick < 30)      b.opcode = bcmfb_pkg::OP_PIXEL;
        else if (pick < 38) b.opcode = bcmfb_pkg::OP_ROW;
        else if (pick < 46) b.opcode = bcmfb_pkg::OP_COL;
        else if (pick < 50) b.opcode = bcmfb_pkg::OP_FILL;
        else if (pick < 72) b.opcode = bcmfb_pkg::OP_QUERY;
        else if (pick < 95) b.opcode = bcmfb_pkg::OP_SCAN;
        else if (pick < 97) b.opcode = OP_SPARE6;
        else                b.opcode = OP_SPARE7;
        // Sparse colors now and then, so queries also find dark pixels.
        if ($urandom_range(0, 3) == 0) begin
            b.red = 8'h00;
            b.green = 8'h00;
            b.blue = 8'(($urandom_range(0, 1) != 0) ? 0 : (1 << $urandom_range(0, 7)));
        end
        return b;
    endfunction

    // Fill the queue of commands: directed first, then random.
    initial begin
        // Scan of the dark display right after reset, every plane extreme.
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_QUERY, 7, 31, 0, 0, 0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_FILL, 0, 0, 8'hFF, 8'hFF, 8'hFF, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_SCAN, 7, 0, 0, 0, 0, 7));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_FILL, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_PIXEL, 0, 0, 8'h01, 0, 0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_PIXEL, 7, 31, 0, 0, 8'h80, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_QUERY, 7, 7, 0, 0, 0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_QUERY, 3, 4, 0, 0, 0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_ROW, 2, 0, 8'hAA, 8'h55, 8'hF0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_COL, 0, 5, 8'h0F, 8'hFF, 8'h00, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_SCAN, 2, 0, 0, 0, 0, 1));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_SCAN, 5, 0, 0, 0, 0, 7));
        // Unused opcodes carry strong colors but must leave the store alone.
        pending_cmds.push_back(make_beat(OP_SPARE6, 1, 1, 8'hFF, 8'hFF, 8'hFF, 0));
        pending_cmds.push_back(make_beat(OP_SPARE7, 1, 1, 8'hFF, 8'hFF, 8'hFF, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_QUERY, 1, 1, 0, 0, 0, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_SCAN, 1, 1, 0, 0, 0, 4));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_COL, 6, 31, 8'hFF, 0, 8'h81, 0));
        pending_cmds.push_back(make_beat(bcmfb_pkg::OP_SCAN, 6, 0, 0, 0, 0, 0));
        for (int n = 0; n < 430; n++) pending_cmds.push_back(random_beat());
    end

    // Driver: offers one command at a time after a random gap.
    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        {i_opcode, i_row, i_column, i_red, i_green, i_blue, i_plane} = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    int send_gap;
    bit offering;
    initial begin
        send_gap = 0;
        offering = 1'b0;
        stim_done = 1'b0;
        errors = 0;
        cycle_count = 0;
        beats_checked = 0;
        queries_sent = 0;
        scans_sent = 0;
        for (int ch = 0; ch < 3; ch++)
            for (int p = 0; p < PLANES; p++)
                for (int r = 0; r < ROWS; r++)
                    for (int j = 0; j < PANELS; j++) shadow_planes[ch][p][r][j] = 8'h00;
    end

    always @(posedge i_clk) begin
        t_beat nxt;
        if (i_rst_n) begin
            if (offering && push && !full) begin
                predict_frame({i_opcode, i_row, i_column, i_red, i_green, i_blue, i_plane});
                if (i_opcode == bcmfb_pkg::OP_QUERY) queries_sent++;
                if (i_opcode == bcmfb_pkg::OP_SCAN) scans_sent++;
                offering = 1'b0;
                // At least half the time the next command follows back to back.
                send_gap = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 19);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds.pop_front();
                    {i_opcode, i_row, i_column, i_red, i_green, i_blue, i_plane} <= nxt;
                    push <= 1'b1;
                    offering = 1'b1;
                end else begin
                    push <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
    end

    // A long hold-off on the result side early in the random part, so the
    // result queue and then the command queue fill and full is seen high.
    initial begin
        hold_off = 1'b0;
        wait (pending_cmds.size() > 0 && pending_cmds.size() < 400);
        hold_off = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Monitor: pops with random stalls and checks each beat in order.
    int pop_gap;
    initial begin
        pop = 1'b0;
        pop_gap = 0;
    end

    always @(posedge i_clk) begin
        bcmfb_pkg::t_res want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat, data_byte", int'(o_data_byte), 0);
                end else begin
                    want = expected_beats.pop_front();
                    if (o_data_byte !== want.data_byte)
                        report_mismatch("data_byte", int'(o_data_byte),
                                        int'(want.data_byte));
                    if (o_led_on !== want.led_on)
                        report_mismatch("led_on", int'(o_led_on), int'(want.led_on));
                    if (o_last !== want.last)
                        report_mismatch("last", int'(o_last), int'(want.last));
                end
                beats_checked++;
                pop_gap = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 19);
            end
            if (hold_off) begin
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on total cycles.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYC) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_count, expected_beats.size());
            $display("** bcm_rgb_matrix_framebuffer: FAILED **");
            $finish;
        end
    end

    // End of run: all commands taken, all beats seen, then a quiet drain
    // in which no stray beat may appear.
    initial begin
        wait (stim_done);
        wait (expected_beats.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (expected_beats.size() != 0)
            report_mismatch("beats left over", expected_beats.size(), 0);
        $display("run covered %0d queries and %0d row scans, %0d result beats checked",
                 queries_sent, scans_sent, beats_checked);
        if (errors == 0) begin
            $display("** bcm_rgb_matrix_framebuffer: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** bcm_rgb_matrix_framebuffer: FAILED **");
        end
        $finish;
    end

endmodule
